// File: rtl/aes_pkg.sv
// shared types, constants and round functions of the aes-128 cipher pipeline
package aes_pkg;

	localparam int BLOCK_W    = 128;
	localparam int HALF_W     = 64;
	localparam int NUM_ROUNDS = 10;
	localparam int CFG_IDX_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [7:0] byte_t;

	localparam logic [0:NUM_ROUNDS-1][7:0] RCON_TBL = {
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	localparam logic [0:255][7:0] SBOX_TBL = {
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic byte_t get_byte(input block_t b, input int n);
		return b[BLOCK_W-1-8*n -: 8];
	endfunction

	function automatic byte_t xtime(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic block_t sub_shift(input block_t s);
		block_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[BLOCK_W-1-8*(r+4*c) -: 8] = SBOX_TBL[get_byte(s, r + 4*((c + r) % 4))];
			end
		end
		return t;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t t;
		byte_t a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2);
			a3 = get_byte(s, 4*c+3);
			t[BLOCK_W-1-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			t[BLOCK_W-1-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			t[BLOCK_W-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			t[BLOCK_W-1-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		return t;
	endfunction

	function automatic block_t next_key(input block_t k, input byte_t rcon);
		logic [31:0] w0, w1, w2, w3, tw;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		tw = {SBOX_TBL[w3[23:16]] ^ rcon, SBOX_TBL[w3[15:8]],
			SBOX_TBL[w3[7:0]], SBOX_TBL[w3[31:24]]};
		w0 = w0 ^ tw;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

// File: rtl/aes128_block_encrypt.sv
// aes-128 block encryption top level: key registers, whitening stage and round chain
// One block enters per clock unless the chain stalls, passing through a whitening
// register followed by a chain of ten round cells, each cell deriving its own round
// key from the previous one as the data passes. The whole chain advances together and
// holds only while the last cell has a result that the output side does not take.
// Key writes take effect for blocks accepted afterwards; write while the chain is empty.
module aes128_block_encrypt import aes_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [HALF_W-1:0]    plain_high,
	input  logic [HALF_W-1:0]    plain_low,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [HALF_W-1:0]    cipher_high,
	output logic [HALF_W-1:0]    cipher_low,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [HALF_W-1:0]    cfg_data
);

	logic [HALF_W-1:0] key_high_q;
	logic [HALF_W-1:0] key_low_q;
	logic              en;
	logic              vld_s[NUM_ROUNDS+1];
	block_t            state_s[NUM_ROUNDS+1];
	block_t            key_s[NUM_ROUNDS+1];

	assign cfg_ready = 1'b1;
	assign en        = !vld_s[NUM_ROUNDS] || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_s[0] <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
			key_s[0]   <= {key_high_q, key_low_q};
		end
	end

	for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_round
		aes_round_cell #(
			.RCON (RCON_TBL[i]),
			.LAST (i == NUM_ROUNDS - 1)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.vld_in    (vld_s[i]),
			.state_in  (state_s[i]),
			.key_in    (key_s[i]),
			.vld_out   (vld_s[i+1]),
			.state_out (state_s[i+1]),
			.key_out   (key_s[i+1])
		);
	end

	assign out_valid   = vld_s[NUM_ROUNDS];
	assign cipher_high = state_s[NUM_ROUNDS][BLOCK_W-1:HALF_W];
	assign cipher_low  = state_s[NUM_ROUNDS][HALF_W-1:0];

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[0])
		else $error("accepted transaction did not enter the chain");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_s[0] == $past(vld_s[0]) && out_valid)
		else $error("chain moved while stalled");

	a_chain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[NUM_ROUNDS-1] |=> out_valid)
		else $error("transaction lost in last round cell");

endmodule

// File: rtl/aes_round_cell.sv
// one cipher round cell: round key derivation and state round, both registered
module aes_round_cell import aes_pkg::*; #(
	parameter logic [7:0] RCON = 8'h01,
	parameter bit LAST = 1'b0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   vld_in,
	input  block_t state_in,
	input  block_t key_in,
	output logic   vld_out,
	output block_t state_out,
	output block_t key_out
);

	block_t rk;
	block_t ss;
	block_t nx;

	always_comb begin
		rk = next_key(key_in, RCON);
		ss = sub_shift(state_in);
		nx = (LAST ? ss : mix_columns(ss)) ^ rk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_out <= nx;
			key_out   <= rk;
		end
	end

endmodule
